>>> rtl/core/xcfr_pkg.sv
package xcfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned GAP_W  = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;     // item accepted this cycle
    logic clr_idx;  // restart the emit index
    logic rd;       // read payload store at the emit index
    logic push;     // load the output register, advance the emit index
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_ok;  // current item completes a valid frame
    logic empty;     // held frame has no payload
    logic last_res;  // emit index is at the final result
  } stat_t;

endpackage

>>> rtl/core/xcfr_ctrl.sv
module xcfr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output xcfr_pkg::cmd_t cmd_o,
  input  xcfr_pkg::stat_t stat_i
);
  import xcfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && stat_i.frame_ok) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = stat_i.empty ? ST_EMIT_WR : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.last_res ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/xcfr_dp.sv
module xcfr_dp #(
  parameter int unsigned MAX_PAYLOAD    = 64,
  parameter int unsigned OVERFLOW_LIMIT = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [xcfr_pkg::BYTE_W-1:0]    start_marker_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]    stop_marker_i,
  input  logic [xcfr_pkg::GAP_W-1:0]     gap_timeout_i,
  input  logic                           op_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  xcfr_pkg::cmd_t                 cmd_i,
  output xcfr_pkg::stat_t                stat_o,
  output logic [xcfr_pkg::BYTE_W-1:0]    frame_id_o,
  output logic [xcfr_pkg::LEN_W-1:0]     payload_length_o,
  output logic [xcfr_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic                           has_payload_o,
  output logic                           last_o
);
  import xcfr_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic        OP_BYTE = 1'b0;
  localparam logic [BYTE_W-1:0] HDR_LEN = BYTE_W'(3);

  // frame state
  logic [BYTE_W-1:0] byte_count_q, byte_count_d;
  logic [BYTE_W-1:0] held_id_q, held_id_d;
  logic [LEN_W-1:0]  held_len_q, held_len_d;
  logic [BYTE_W-1:0] run_xor_q, run_xor_d;
  logic              disc_q, disc_d;
  logic [GAP_W-1:0]  gap_q, gap_d;
  logic [AW-1:0]     emit_idx_q;

  // payload store and emit path
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_q;

  logic [BYTE_W-1:0] pos, pay_end, wr_off;
  logic [BYTE_W:0]   count;
  logic              disc_n, ok, wr_en;

  assign pos     = byte_count_q;
  assign pay_end = BYTE_W'(held_len_q) + HDR_LEN;
  assign wr_off  = pos - HDR_LEN;
  assign count   = {1'b0, pos} + 1'b1;

  // frame parser for one received byte
  always_comb begin
    disc_n    = disc_q;
    run_xor_d = run_xor_q;
    held_id_d = held_id_q;
    held_len_d = held_len_q;
    wr_en     = 1'b0;
    ok        = 1'b0;
    if (!disc_q) begin
      if (pos == '0) begin
        if (rx_byte_i != start_marker_i) disc_n = 1'b1;
        run_xor_d = '0;
      end else if (pos == BYTE_W'(1)) begin
        held_id_d = rx_byte_i;
      end else if (pos == BYTE_W'(2)) begin
        held_len_d = rx_byte_i[LEN_W-1:0];
        if (rx_byte_i > BYTE_W'(MAX_PAYLOAD)) disc_n = 1'b1;
      end else if (pos < pay_end) begin
        wr_en     = 1'b1;
        run_xor_d = run_xor_q ^ rx_byte_i;
      end else if (pos == pay_end) begin
        if (rx_byte_i != run_xor_q) disc_n = 1'b1;
      end else begin
        if (rx_byte_i == stop_marker_i) begin
          ok = 1'b1;
        end else begin
          disc_n = 1'b1;
        end
      end
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    disc_d       = disc_q;
    gap_d        = gap_q;
    if (op_i == OP_BYTE) begin
      gap_d = gap_timeout_i;
      if (ok || (count > (BYTE_W+1)'(OVERFLOW_LIMIT))) begin
        byte_count_d = '0;
        disc_d       = 1'b0;
      end else begin
        byte_count_d = count[BYTE_W-1:0];
        disc_d       = disc_n;
      end
    end else if (gap_q != '0) begin
      gap_d = gap_q - 1'b1;
      // timeout expires: drop the partial frame
      if (gap_q == GAP_W'(1)) begin
        byte_count_d = '0;
        disc_d       = 1'b0;
      end
    end
  end

  assign stat_o.frame_ok = (op_i == OP_BYTE) && ok;
  assign stat_o.empty    = (held_len_q == '0);
  assign stat_o.last_res = stat_o.empty || ((LEN_W'(emit_idx_q) + 1'b1) == held_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      held_id_q    <= '0;
      held_len_q   <= '0;
      run_xor_q    <= '0;
      disc_q       <= 1'b0;
      gap_q        <= '0;
      emit_idx_q   <= '0;
    end else begin
      if (cmd_i.take) begin
        byte_count_q <= byte_count_d;
        disc_q       <= disc_d;
        gap_q        <= gap_d;
        if (op_i == OP_BYTE) begin
          held_id_q  <= held_id_d;
          held_len_q <= held_len_d;
          run_xor_q  <= run_xor_d;
        end
      end
      if (cmd_i.clr_idx) begin
        emit_idx_q <= '0;
      end else if (cmd_i.push) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (op_i == OP_BYTE) && wr_en) begin
      mem[wr_off[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[emit_idx_q];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      frame_id_o       <= held_id_q;
      payload_length_o <= held_len_q;
      payload_byte_o   <= stat_o.empty ? '0 : rd_q;
      has_payload_o    <= !stat_o.empty;
      last_o           <= stat_o.last_res;
    end
  end

endmodule

>>> rtl/core/xor_checked_frame_receiver_top.sv
// framed packet receiver with xor checksum
// input channel (in_valid_i/in_ready_o): op_i = 0 carries a received byte in
// rx_byte_i, op_i = 1 is one timer tick; frames are start marker, id, length,
// payload, xor of the payload, stop marker
// output channel (out_valid_o/out_ready_i): a valid frame gives one item per
// payload byte, each with id and length, last_o on the final one; an empty
// payload gives a single item with has_payload_o low
// items are taken only while idle; the stop byte of a valid frame starts
// emission, during which no item is taken: each payload result is a payload
// store read, then an output register load, and an empty-frame result is an
// output register load only; the load waits while the receiver stalls
// the output register holds a result while out_ready_i is low; the block keeps
// taking bytes and ticks while a frame's final result waits, only the next
// frame's run waits
// reset: markers 0xaa/0x55, gap timeout 100 ticks, parser idle; the payload
// store is not cleared, only entries of the current frame are read
// config over apb at byte addresses 0, 4, 8; pready is always high
module xor_checked_frame_receiver_top #(
  parameter int unsigned MAX_PAYLOAD    = 64,
  parameter int unsigned OVERFLOW_LIMIT = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]    rx_byte_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [xcfr_pkg::BYTE_W-1:0]    frame_id_o,
  output logic [xcfr_pkg::LEN_W-1:0]     payload_length_o,
  output logic [xcfr_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic                           has_payload_o,
  output logic                           last_o
);
  import xcfr_pkg::*;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP  = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  logic [BYTE_W-1:0] start_marker_q;
  logic [BYTE_W-1:0] stop_marker_q;
  logic [GAP_W-1:0]  gap_timeout_q;
  logic              cfg_wr;

  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= BYTE_W'(170);
      stop_marker_q  <= BYTE_W'(85);
      gap_timeout_q  <= GAP_W'(100);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START: start_marker_q <= pwdata[BYTE_W-1:0];
        REG_STOP:  stop_marker_q  <= pwdata[BYTE_W-1:0];
        REG_GAP:   gap_timeout_q  <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START: prdata = {{(32-BYTE_W){1'b0}}, start_marker_q};
      REG_STOP:  prdata = {{(32-BYTE_W){1'b0}}, stop_marker_q};
      REG_GAP:   prdata = {{(32-GAP_W){1'b0}}, gap_timeout_q};
      default:   prdata = '0;
    endcase
  end

  xcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  xcfr_dp #(
    .MAX_PAYLOAD    (MAX_PAYLOAD),
    .OVERFLOW_LIMIT (OVERFLOW_LIMIT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_marker_i   (start_marker_q),
    .stop_marker_i    (stop_marker_q),
    .gap_timeout_i    (gap_timeout_q),
    .op_i             (op_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .frame_id_o       (frame_id_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .has_payload_o    (has_payload_o),
    .last_o           (last_o)
  );

`ifndef NO_ASSERTIONS
  // no result is loaded while input items are being taken
  a_push_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !in_ready_o)
    else $error("result loaded while input open");

  // an empty-frame result is always the only and final one
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_payload_o) |-> (last_o && (payload_length_o == '0)
      && (payload_byte_o == '0)))
    else $error("malformed empty-frame result");

  // a payload result never claims a length outside the store
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_payload_o) |-> ((payload_length_o != '0)
      && (payload_length_o <= LEN_W'(MAX_PAYLOAD))))
    else $error("payload length out of range");
`endif

endmodule
